// ===== hdl/centered_moving_average_detrend_defines.svh =====
// Assertion macros for the moving-average detrend block.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef CENTERED_MOVING_AVERAGE_DETREND_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_DETREND_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent
`define CMAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmad: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define CMAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmad: next-cycle check failed");

`else

`define CMAD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CMAD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/cmad_pkg.sv =====
`timescale 1ns / 1ps

package cmad_pkg;

    localparam int MAX_HALF_WIDTH = 31;
    localparam int SAMPLE_BITS    = 24;
    localparam int RESID_BITS     = SAMPLE_BITS + 1;
    localparam int HW_BITS        = 5;
    localparam logic [HW_BITS-1:0] HALF_WIDTH_RESET = HW_BITS'(1);

    // Sample ring: one full window plus one slot of slack for the next write
    localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 2;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Counters for window positions, fill level and half width
    localparam int WIN_BITS = (RING_AW > HW_BITS) ? RING_AW : HW_BITS;

    // Window sum and the rounding divider
    localparam int SUM_BITS  = SAMPLE_BITS + WIN_BITS;
    localparam int DIV_BITS  = SUM_BITS;
    localparam int DEN_BITS  = WIN_BITS + 1;
    localparam int STEP_BITS = $clog2(DIV_BITS);

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One result to compute: positions counted back from the newest sample
    typedef struct packed {
        logic [RING_AW-1:0]  newest;
        logic [WIN_BITS-1:0] centre_back;
        logic [WIN_BITS-1:0] far_back;
        logic                last;
    } t_cmd;

    // What the back end tells the front end
    typedef struct packed {
        logic               busy;
        logic [RING_AW-1:0] newest;
    } t_back_status;

    // Clamp the half width to the largest window the ring holds
    function automatic logic [WIN_BITS-1:0] eff_half(input logic [HW_BITS-1:0] hw);
        logic [WIN_BITS-1:0] w;
        w = WIN_BITS'(hw);
        if (w > WIN_BITS'(MAX_HALF_WIDTH)) begin
            w = WIN_BITS'(MAX_HALF_WIDTH);
        end
        return w;
    endfunction

endpackage

// ===== hdl/cmad_in_if.sv =====
`timescale 1ns / 1ps

interface cmad_in_if;
    import cmad_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== hdl/cmad_out_if.sv =====
`timescale 1ns / 1ps

interface cmad_out_if;
    import cmad_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] trend;
    logic signed [RESID_BITS-1:0]  residual;
    logic                          last_result;

    modport source (output valid, output trend, output residual, output last_result,
                    input ready);
    modport sink   (input valid, input trend, input residual, input last_result,
                    output ready);
endinterface

// ===== hdl/cmad_cfg_if.sv =====
`timescale 1ns / 1ps

interface cmad_cfg_if;
    import cmad_pkg::*;

    logic               valid;
    logic               ready;
    logic [HW_BITS-1:0] half_width;

    modport source (output valid, output half_width, input ready);
    modport sink   (input valid, input half_width, output ready);
endinterface

// ===== hdl/cmad_ram.sv =====
`timescale 1ns / 1ps

module cmad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cmad_cmd_fifo.sv =====
`timescale 1ns / 1ps

module cmad_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmad_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output cmad_pkg::t_cmd  o_cmd,
    output logic            o_empty,
    output logic            o_full
);
    import cmad_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rd];

    // Store commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (Q_AW + 1)'(1);
            end
        end
    end

endmodule

// ===== hdl/cmad_front.sv =====
`timescale 1ns / 1ps

module cmad_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cmad_in_if.sink                         i_in,
    cmad_cfg_if.sink                        i_cfg,
    input  cmad_pkg::t_back_status          i_back,
    input  logic                            i_q_empty,
    input  logic                            i_q_full,
    output logic                            o_push,
    output cmad_pkg::t_cmd                  o_cmd,
    output logic                            o_we,
    output logic [cmad_pkg::RING_AW-1:0]    o_waddr,
    output logic [cmad_pkg::SAMPLE_BITS-1:0] o_wdata
);
    import cmad_pkg::*;

    typedef enum logic {S_IDLE, S_EMIT} t_state;

    t_state              r_state;
    logic [HW_BITS-1:0]  r_half;
    logic [RING_AW-1:0]  r_wp;
    logic [RING_AW-1:0]  r_newest;
    logic [WIN_BITS-1:0] r_seen;
    logic [WIN_BITS-1:0] r_off;
    logic [WIN_BITS-1:0] r_k;
    logic [WIN_BITS-1:0] r_win_seen;
    logic                r_flush;

    logic [WIN_BITS-1:0] h;
    logic [WIN_BITS-1:0] h_p1;
    logic [WIN_BITS-1:0] win;
    logic [WIN_BITS-1:0] n_seen;
    logic [WIN_BITS-1:0] n_off;
    logic [WIN_BITS-1:0] reach;
    logic [WIN_BITS-1:0] oldest;
    logic [WIN_BITS-1:0] far;
    logic                safe;
    logic                accept;

    assign h    = eff_half(r_half);
    assign h_p1 = h + WIN_BITS'(1);
    assign win  = WIN_BITS'({h, 1'b0}) + WIN_BITS'(1);

    // The back end may still read one window behind the newest word; one
    // write ahead of it is safe, a second one is not. Hold intake while a
    // half width write is offered.
    assign safe   = !i_back.busy || (i_back.newest == r_newest);
    assign i_in.ready = (r_state == S_IDLE) && i_q_empty && safe && !i_cfg.valid;
    assign accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Fill level and outstanding count after this word
    assign n_seen = (r_seen < win) ? r_seen + WIN_BITS'(1) : win;
    assign n_off  = (r_off < h_p1) ? r_off + WIN_BITS'(1) : h_p1;

    // Window reach for the current command, cut at the sequence start
    assign reach  = r_k + h;
    assign oldest = r_win_seen - WIN_BITS'(1);
    assign far    = (reach > oldest) ? oldest : reach;

    assign o_push             = (r_state == S_EMIT) && !i_q_full;
    assign o_cmd.newest       = r_newest;
    assign o_cmd.centre_back  = r_k;
    assign o_cmd.far_back     = far;
    assign o_cmd.last         = r_flush && (r_k == '0);

    // Ring write
    assign o_we    = accept;
    assign o_waddr = r_wp;
    assign o_wdata = i_in.sample;

    // Classify words and issue commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_half     <= HALF_WIDTH_RESET;
            r_wp       <= '0;
            r_newest   <= '0;
            r_seen     <= '0;
            r_off      <= '0;
            r_k        <= '0;
            r_win_seen <= '0;
            r_flush    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_newest   <= r_wp;
                        r_wp       <= (r_wp == RING_AW'(RING_DEPTH - 1)) ?
                                      '0 : r_wp + RING_AW'(1);
                        r_win_seen <= n_seen;
                        if (i_in.last_sample) begin
                            // flush every outstanding result, oldest first
                            r_k     <= n_off - WIN_BITS'(1);
                            r_flush <= 1'b1;
                            r_seen  <= '0;
                            r_off   <= '0;
                            r_state <= S_EMIT;
                        end else if (n_off > h) begin
                            r_k     <= h;
                            r_flush <= 1'b0;
                            r_seen  <= n_seen;
                            r_off   <= h;
                            r_state <= S_EMIT;
                        end else begin
                            r_seen <= n_seen;
                            r_off  <= n_off;
                        end
                    end
                end
                S_EMIT: begin
                    if (o_push) begin
                        if (!r_flush || (r_k == '0)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k - WIN_BITS'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // New half width drops the sequence in progress
            if (i_cfg.valid) begin
                r_half <= i_cfg.half_width;
                r_seen <= '0;
                r_off  <= '0;
            end
        end
    end

endmodule

// ===== hdl/cmad_back.sv =====
`timescale 1ns / 1ps

module cmad_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cmad_pkg::t_cmd                   i_cmd,
    input  logic                             i_q_empty,
    output logic                             o_pop,
    output logic [cmad_pkg::RING_AW-1:0]     o_raddr,
    input  logic [cmad_pkg::SAMPLE_BITS-1:0] i_rdata,
    cmad_out_if.source                       o_out,
    output cmad_pkg::t_back_status           o_status
);
    import cmad_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_PUT} t_state;

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [WIN_BITS-1:0]    r_i;
    logic                   r_rd_vld;
    logic [WIN_BITS-1:0]    r_rd_idx;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_centre;
    logic                   r_neg;
    logic [DIV_BITS-1:0]    r_num;
    logic [DEN_BITS-1:0]    r_den;
    logic [DEN_BITS-1:0]    r_rem;
    logic [STEP_BITS-1:0]   r_step;
    logic                   r_ov;
    logic [SAMPLE_BITS-1:0] r_trend;
    logic [RESID_BITS-1:0]  r_resid;
    logic                   r_olast;

    logic                   issuing;
    logic [WIN_BITS:0]      base;
    logic [WIN_BITS:0]      addr_wide;
    logic [SUM_BITS-1:0]    rdata_ext;
    logic [SUM_BITS-1:0]    mag;
    logic [WIN_BITS-1:0]    cnt;
    logic [DEN_BITS:0]      trial;
    logic                   qbit;
    logic [SAMPLE_BITS-1:0] q;
    logic [SAMPLE_BITS-1:0] n_trend;
    logic [RESID_BITS-1:0]  n_resid;
    logic                   load_out;

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_status.busy   = (r_state != S_IDLE);
    assign o_status.newest = r_cmd.newest;

    // Ring address of the word r_i positions behind the newest one
    assign issuing   = (r_state == S_READ) && (r_i <= r_cmd.far_back);
    assign base      = (WIN_BITS + 1)'(r_cmd.newest);
    assign addr_wide = (base >= (WIN_BITS + 1)'(r_i)) ?
                       base - (WIN_BITS + 1)'(r_i) :
                       base + (WIN_BITS + 1)'(RING_DEPTH) - (WIN_BITS + 1)'(r_i);
    assign o_raddr   = addr_wide[RING_AW-1:0];

    assign rdata_ext = {{(SUM_BITS - SAMPLE_BITS){i_rdata[SAMPLE_BITS-1]}}, i_rdata};

    // Divider set-up: round half away from zero as (2|s| + n) / 2n
    assign mag = r_sum[SUM_BITS-1] ? (~r_sum + SUM_BITS'(1)) : r_sum;
    assign cnt = r_cmd.far_back + WIN_BITS'(1);

    // One restoring step
    assign trial = {r_rem, r_num[DIV_BITS-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    // Signed result
    assign q       = r_num[SAMPLE_BITS-1:0];
    assign n_trend = r_neg ? (~q + SAMPLE_BITS'(1)) : q;
    assign n_resid = {r_centre[SAMPLE_BITS-1], r_centre} - {n_trend[SAMPLE_BITS-1], n_trend};
    assign load_out = (r_state == S_PUT) && (!r_ov || o_out.ready);

    assign o_out.valid       = r_ov;
    assign o_out.trend       = r_trend;
    assign o_out.residual    = r_resid;
    assign o_out.last_result = r_olast;

    // Sum the window, divide, hand the word to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= '0;
            r_i      <= '0;
            r_rd_vld <= 1'b0;
            r_rd_idx <= '0;
            r_sum    <= '0;
            r_centre <= '0;
            r_neg    <= 1'b0;
            r_num    <= '0;
            r_den    <= '0;
            r_rem    <= '0;
            r_step   <= '0;
            r_ov     <= 1'b0;
            r_trend  <= '0;
            r_resid  <= '0;
            r_olast  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd    <= i_cmd;
                        r_i      <= '0;
                        r_sum    <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_vld <= issuing;
                    r_rd_idx <= r_i;
                    if (issuing) begin
                        r_i <= r_i + WIN_BITS'(1);
                    end
                    if (r_rd_vld) begin
                        r_sum <= r_sum + rdata_ext;
                        if (r_rd_idx == r_cmd.centre_back) begin
                            r_centre <= i_rdata;
                        end
                    end
                    if (!issuing && !r_rd_vld) begin
                        r_neg   <= r_sum[SUM_BITS-1];
                        r_num   <= {mag[DIV_BITS-2:0], 1'b0} + DIV_BITS'(cnt);
                        r_den   <= {cnt, 1'b0};
                        r_rem   <= '0;
                        r_step  <= STEP_BITS'(DIV_BITS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= qbit ? DEN_BITS'(trial - {1'b0, r_den}) : DEN_BITS'(trial);
                    r_num <= {r_num[DIV_BITS-2:0], qbit};
                    r_step <= r_step - STEP_BITS'(1);
                    if (r_step == '0) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Output register: load a new word or drop the one taken
            if (load_out) begin
                r_ov    <= 1'b1;
                r_trend <= n_trend;
                r_resid <= n_resid;
                r_olast <= r_cmd.last;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/centered_moving_average_detrend.sv =====
`timescale 1ns / 1ps
// Centred moving-average detrend.
// i_in carries signed samples with last_sample marking the end of a
// sequence; o_out returns one word per sample with the rounded window mean
// (trend), sample minus trend (residual) and last_result on the final one.
// i_cfg writes half_width (always ready); write it only while idle, it
// starts a fresh sequence. Reset sets half_width to 1 and empties the block.
// Results run half_width samples behind the input; the last sample flushes
// all outstanding results, oldest first.
// Each result takes far + 1 reads of the sample RAM to sum the window
// (far = 2 * half_width in steady state) and 30 steps of the serial
// divider. The back end works on one result at a time: it takes the next
// command only after the current word has gone to the output register.
// A four-entry command queue separates sample intake from the arithmetic;
// a new sample is taken once the queue has drained. When the receiver
// stalls, the finished word waits in the output register, the back end
// finishes the next word and then holds, and intake stops soon after.
module centered_moving_average_detrend (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmad_in_if.sink    i_in,
    cmad_cfg_if.sink   i_cfg,
    cmad_out_if.source o_out
);
    import cmad_pkg::*;

`include "centered_moving_average_detrend_defines.svh"

    t_cmd                   front_cmd;
    t_cmd                   queue_cmd;
    t_back_status           back_status;
    logic                   push;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;
    logic                   ram_we;
    logic [RING_AW-1:0]     ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [RING_AW-1:0]     ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    cmad_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_back    (back_status),
        .i_q_empty (q_empty),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (front_cmd),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata)
    );

    cmad_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cmad_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cmad_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (queue_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_raddr   (ram_raddr),
        .i_rdata   (ram_rdata),
        .o_out     (o_out),
        .o_status  (back_status)
    );

    // Queue never overflows or underflows
    `CMAD_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, push, !q_full)
    `CMAD_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, pop, !q_empty)
    // Intake only with a drained queue, so the ring is never overwritten early
    `CMAD_ASSERT_IMP(a_take_drained, i_clk, i_rst_n, i_in.valid && i_in.ready, q_empty)
    // A popped command keeps the back end busy
    `CMAD_ASSERT_NXT(a_pop_busy, i_clk, i_rst_n, pop, back_status.busy)

endmodule

// ===== tb/centered_moving_average_detrend_tb.sv =====
`timescale 1ns / 1ps

module centered_moving_average_detrend_tb;
    import cmad_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 1500;
    localparam int HOLD_PHASE    = 0;
    localparam int N_PHASES      = 7;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_sample_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] trend;
        logic signed [RESID_BITS-1:0]  residual;
        logic                          last;
    } t_detrend_word;

    logic clk;
    logic rst_n;

    cmad_in_if  in_ch ();
    cmad_cfg_if cfg_ch ();
    cmad_out_if out_ch ();

    centered_moving_average_detrend dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Words waiting to be sent and results still owed by the block
    t_sample_word  sample_q [$];
    t_detrend_word detrend_due [$];
    int            mismatches = 0;

    // Own copy of the block state
    logic signed [SAMPLE_BITS-1:0] hist [RING_DEPTH];
    int unsigned                   head   = 0;
    int unsigned                   filled = 0;
    int unsigned                   owed   = 0;
    int unsigned                   hw_now = HALF_WIDTH_RESET;

    // Handshake pacing state
    int   send_gap   = 0;
    int   send_calm  = 0;
    int   recv_gap   = 0;
    int   recv_calm  = 0;
    int   hold_left;
    logic hold_kick;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(15, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: begin
                return SAMPLE_MAX;
            end
            1: begin
                return SAMPLE_MIN;
            end
            2: begin
                return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
            end
            default: begin
                return SAMPLE_BITS'($urandom);
            end
        endcase
    endfunction

    // Sample stored k positions before the newest one
    function automatic longint hist_back(int k);
        return longint'(hist[(int'(head) + RING_DEPTH - 1 - k) % RING_DEPTH]);
    endfunction

    // Rounded mean of the cut window around the sample k back, and its residual
    function automatic t_detrend_word window_result(int k, int h, logic fin);
        int            reach;
        int            cnt;
        longint        total;
        longint        centre;
        longint        mean;
        longint unsigned mag;
        longint unsigned q;
        t_detrend_word w;
        reach = k + h;
        if (filled > 0 && reach > int'(filled) - 1) begin
            reach = int'(filled) - 1;
        end
        cnt   = reach + 1;
        total = 0;
        for (int i = 0; i <= reach; i++) begin
            total += hist_back(i);
        end
        centre     = hist_back(k);
        mag        = (total < 0) ? longint'(-total) : longint'(total);
        q          = (2 * mag + cnt) / (2 * longint'(cnt));
        mean       = (total < 0) ? -longint'(q) : longint'(q);
        w.trend    = SAMPLE_BITS'(mean);
        w.residual = RESID_BITS'(centre - mean);
        w.last     = fin;
        return w;
    endfunction

    // Advance the state by one accepted word and queue the results it causes
    function automatic void take_sample(logic signed [SAMPLE_BITS-1:0] s, logic fin);
        int h;
        int span;
        h    = (hw_now > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : int'(hw_now);
        span = 2 * h + 1;
        hist[head] = s;
        head = (head + 1) % RING_DEPTH;
        if (filled < span) begin
            filled++;
        end
        if (owed < h + 1) begin
            owed++;
        end
        if (fin) begin
            for (int k = int'(owed) - 1; k >= 0; k--) begin
                detrend_due.insert(detrend_due.size(), window_result(k, h, k == 0));
            end
            filled = 0;
            owed   = 0;
        end else if (owed > h) begin
            detrend_due.insert(detrend_due.size(), window_result(h, h, 1'b0));
            owed = h;
        end
    endfunction

    // Offer queued samples, with random gaps between words
    always @(posedge clk) begin : drive_samples
        t_sample_word w;
        if (!rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.sample      <= '0;
            in_ch.last_sample <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                take_sample(in_ch.sample, in_ch.last_sample);
            end
            if (send_calm > 0) begin
                send_calm--;
            end else if ($urandom_range(0, 299) == 0) begin
                send_calm = $urandom_range(100, 400);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    w = sample_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.sample      <= w.sample;
                    in_ch.last_sample <= w.last;
                    if (send_calm == 0 && $urandom_range(0, 3) == 0) begin
                        send_gap = pick_gap();
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Count down a long receiver hold-off once kicked
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Check each result word against the oldest one owed, and pace ready
    always @(posedge clk) begin : watch_results
        t_detrend_word want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (detrend_due.size() == 0) begin
                    $error("unexpected word: trend %0d residual %0d last_result %0b",
                           out_ch.trend, out_ch.residual, out_ch.last_result);
                    mismatches++;
                end else begin
                    want = detrend_due.pop_front();
                    if (out_ch.trend !== want.trend) begin
                        $error("trend: expected %0d, got %0d", want.trend, out_ch.trend);
                        mismatches++;
                    end
                    if (out_ch.residual !== want.residual) begin
                        $error("residual: expected %0d, got %0d",
                               want.residual, out_ch.residual);
                        mismatches++;
                    end
                    if (out_ch.last_result !== want.last) begin
                        $error("last_result: expected %0b, got %0b",
                               want.last, out_ch.last_result);
                        mismatches++;
                    end
                end
            end
            if (recv_calm > 0) begin
                recv_calm--;
            end else if ($urandom_range(0, 299) == 0) begin
                recv_calm = $urandom_range(100, 400);
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (recv_calm == 0 && $urandom_range(0, 4) == 0) begin
                    recv_gap = pick_gap();
                end
            end
        end
    end

    task automatic queue_word(input logic signed [SAMPLE_BITS-1:0] s, input logic fin);
        sample_q.insert(sample_q.size(), t_sample_word'{sample: s, last: fin});
    endtask

    // Write half_width and restart the sequence in the local state
    task automatic write_half_width(input logic [HW_BITS-1:0] v);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.half_width <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        hw_now = v;
        filled = 0;
        owed   = 0;
        @(negedge clk);
    endtask

    // Hold the sender until every owed result has arrived
    task automatic drain_results();
        while (sample_q.size() != 0 || in_ch.valid || detrend_due.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Drain, then let any word still inside the block die out
    task automatic go_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        logic [HW_BITS-1:0] hw_plan [N_PHASES];
        int                 budget  [N_PHASES];
        int                 left;
        int                 len;
        int                 h;
        logic               broken;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.last_sample = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.half_width = '0;
        out_ch.ready      = 1'b0;
        hold_kick         = 1'b0;
        rst_n             = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset half width: extremes, ties on both signs, single-word sequence
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word(SAMPLE_MIN, 1'b0);
        queue_word(SAMPLE_MIN, 1'b1);
        queue_word(-24'sd1, 1'b0);
        queue_word(24'sd0, 1'b1);
        queue_word(24'sd1, 1'b0);
        queue_word(24'sd0, 1'b1);
        queue_word(SAMPLE_MIN, 1'b1);
        go_idle();

        // Zero half width: trend follows the sample
        write_half_width(HW_BITS'(0));
        queue_word(24'sd5, 1'b0);
        queue_word(-24'sd7, 1'b0);
        queue_word(SAMPLE_MAX, 1'b1);
        go_idle();

        // Widest window on a sequence shorter than it
        write_half_width(HW_BITS'(MAX_HALF_WIDTH));
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word(SAMPLE_MAX, 1'b0);
        queue_word(SAMPLE_MIN, 1'b1);
        go_idle();

        // Abandon an open sequence with a register write
        write_half_width(HW_BITS'(2));
        queue_word(24'sd10, 1'b0);
        queue_word(24'sd20, 1'b0);
        queue_word(24'sd30, 1'b0);
        go_idle();
        write_half_width(HW_BITS'(3));
        queue_word(-24'sd3, 1'b0);
        queue_word(24'sd4, 1'b0);
        queue_word(-24'sd5, 1'b0);
        queue_word(24'sd6, 1'b0);
        queue_word(24'h555555, 1'b0);
        queue_word(24'hAAAAAA, 1'b1);
        go_idle();

        // Random phases, one half width each
        hw_plan = '{HW_BITS'(2), HW_BITS'(31), HW_BITS'(1), HW_BITS'(0),
                    HW_BITS'(9), HW_BITS'(4), HW_BITS'($urandom_range(0, 31))};
        budget  = '{40, 70, 25, 20, 35, 30, 30};
        for (int p = 0; p < N_PHASES; p++) begin
            write_half_width(hw_plan[p]);
            h    = hw_plan[p];
            left = budget[p];
            while (left > 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        len = 1;
                    end
                    1, 2, 3: begin
                        len = $urandom_range(1, h + 1);
                    end
                    default: begin
                        len = $urandom_range(h + 2, 3 * h + 6);
                    end
                endcase
                if (len > left) begin
                    len = left;
                end
                broken = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++) begin
                    queue_word(random_sample(), (i == len - 1) && !broken);
                end
                left -= len;
                if (p != HOLD_PHASE && $urandom_range(0, 7) == 0) begin
                    drain_results();
                end
            end
            // Stall the receiver with the whole phase queued behind it
            if (p == HOLD_PHASE) begin
                @(posedge clk);
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
                @(negedge clk);
            end
            go_idle();
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Give up well past the slowest correct run
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cmad_pkg.sv
hdl/cmad_in_if.sv
hdl/cmad_out_if.sv
hdl/cmad_cfg_if.sv
hdl/cmad_ram.sv
hdl/cmad_cmd_fifo.sv
hdl/cmad_front.sv
hdl/cmad_back.sv
hdl/centered_moving_average_detrend.sv
tb/centered_moving_average_detrend_tb.sv
